>>> src/crps_pkg.sv
package crps_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int POS_W = 32;
	localparam int QUAT_W = 16;
	localparam int SPP_W = 5;
	localparam logic [SPP_W-1:0] SPP_RESET = 5'd10;
	localparam int STEP_W = 5;
	localparam int CORDIC_STEPS = 31;
	localparam int MUL_STEPS = 6;
	localparam int HW = 38;      // Horner accumulator width
	localparam int VEC_W = 44;   // CORDIC x/y width
	localparam int ANG_W = 36;   // CORDIC angle width, 2^32 per turn
	localparam int NORM_BIT = 40;
	localparam logic signed [VEC_W-1:0] INV_GAIN_Q30 = 44'sd652032874;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 36'sd1073741824;
	localparam logic signed [QUAT_W-1:0] Q14_ONE = 16'sd16384;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD_IN,
		OP_LOAD_SEGA,
		OP_LOAD_SEGB,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_MUL,
		OP_DIFF,
		OP_NORM,
		OP_PREROT,
		OP_VEC,
		OP_HALF,
		OP_ROT,
		OP_EMIT,
		OP_ECHO,
		OP_SHIFT_WIN
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [STEP_W-1:0] idx;
		logic [SPP_W-1:0]  s;
		logic [SPP_W-1:0]  spp;
		logic              sel;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic end_q;
		logic zero;
		logic norm_done;
	} stat_t;

	// atan(2^-i) in units of 2^32 per turn
	function automatic logic [29:0] atan_lookup(input logic [STEP_W-1:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0: r = 30'd536870912;
			5'd1: r = 30'd316933406;
			5'd2: r = 30'd167458907;
			5'd3: r = 30'd85004756;
			5'd4: r = 30'd42667331;
			5'd5: r = 30'd21354465;
			5'd6: r = 30'd10679838;
			5'd7: r = 30'd5340245;
			5'd8: r = 30'd2670163;
			5'd9: r = 30'd1335087;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			5'd24: r = 30'd41;
			5'd25: r = 30'd20;
			5'd26: r = 30'd10;
			5'd27: r = 30'd5;
			5'd28: r = 30'd3;
			5'd29: r = 30'd1;
			5'd30: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

>>> src/crps_dp.sv
module crps_dp import crps_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output stat_t                    st,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic signed [QUAT_W-1:0] quat_x,
	input  logic signed [QUAT_W-1:0] quat_y,
	input  logic signed [QUAT_W-1:0] quat_z,
	input  logic signed [QUAT_W-1:0] quat_w,
	input  logic                     path_end,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [POS_W-1:0]  out_x,
	output logic signed [POS_W-1:0]  out_y,
	output logic signed [POS_W-1:0]  out_z,
	output logic signed [QUAT_W-1:0] out_qx,
	output logic signed [QUAT_W-1:0] out_qy,
	output logic signed [QUAT_W-1:0] out_qz,
	output logic signed [QUAT_W-1:0] out_qw,
	output logic                     run_last
);

	localparam int NW = FRAC_BITS + SPP_W;
	localparam int TW = FRAC_BITS + 1;
	localparam int PW = HW + TW + 1;
	localparam logic signed [PW-1:0] HALF_F = PW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [PW-1:0] HALF_F1 = PW'(1) <<< FRAC_BITS;
	localparam logic signed [VEC_W-1:0] NORM_HI = VEC_W'(1) <<< NORM_BIT;
	localparam logic signed [VEC_W-1:0] NORM_LO = -NORM_HI;
	localparam logic signed [HW-1:0] SAT_HI = HW'(2147483647);
	localparam logic signed [HW-1:0] SAT_LO = ~SAT_HI;

	function automatic logic signed [QUAT_W-1:0] q14(input logic signed [VEC_W-1:0] v);
		logic signed [VEC_W-1:0] r;
		r = (v + VEC_W'(32768)) >>> 16;
		if (r > VEC_W'(16384))
			return Q14_ONE;
		else if (r < -VEC_W'(16384))
			return -Q14_ONE;
		else
			return r[QUAT_W-1:0];
	endfunction

	// latched input item
	logic signed [POS_W-1:0]  nx_q, ny_q, nz_q;
	logic signed [QUAT_W-1:0] nqx_q, nqy_q, nqz_q, nqw_q;
	logic                     end_q;
	// waypoint window, entry 2 newest
	logic signed [POS_W-1:0]  wx_q [3];
	logic signed [POS_W-1:0]  wy_q [3];
	// segment coefficients
	logic signed [HW-1:0]     bx_q, ax_q, cx_q, by_q, ay_q, cy_q;
	logic signed [POS_W-1:0]  x1_q, y1_q;
	// t divider
	logic [NW-1:0]            num_q, quo_q;
	logic [SPP_W:0]           rem_q;
	// Horner and sample
	logic signed [HW-1:0]     hx_q, hy_q;
	logic signed [POS_W-1:0]  sx_q, sy_q;
	// CORDIC
	logic signed [VEC_W-1:0]  vx_q, vy_q;
	logic signed [ANG_W-1:0]  z_q;
	logic                     zero_q;
	logic                     out_valid_q;

	// segment end points
	logic signed [POS_W-1:0] p0x, p1x, p2x, p3x, p0y, p1y, p2y, p3y;
	always_comb begin
		if (cmd.op == OP_LOAD_SEGB) begin
			p0x = cmd.sel ? wx_q[1] : wx_q[2];
			p0y = cmd.sel ? wy_q[1] : wy_q[2];
			p1x = wx_q[2]; p1y = wy_q[2];
			p2x = nx_q;    p2y = ny_q;
			p3x = nx_q;    p3y = ny_q;
		end else begin
			p0x = cmd.sel ? wx_q[0] : wx_q[1];
			p0y = cmd.sel ? wy_q[0] : wy_q[1];
			p1x = wx_q[1]; p1y = wy_q[1];
			p2x = wx_q[2]; p2y = wy_q[2];
			p3x = nx_q;    p3y = ny_q;
		end
	end

	logic signed [HW-1:0] e0x, e1x, e2x, e3x, e0y, e1y, e2y, e3y;
	assign e0x = HW'(p0x); assign e1x = HW'(p1x); assign e2x = HW'(p2x); assign e3x = HW'(p3x);
	assign e0y = HW'(p0y); assign e1y = HW'(p1y); assign e2y = HW'(p2y); assign e3y = HW'(p3y);

	// shared multiplier
	logic signed [HW-1:0] mul_a, mul_add, h_next, fin;
	logic signed [PW-1:0] prod, rnd_a, rnd_b;
	logic                 use_y;
	always_comb begin
		use_y = (cmd.idx >= STEP_W'(3));
		mul_a = use_y ? hy_q : hx_q;
		mul_add = use_y ? cy_q : cx_q;
		if (cmd.idx == STEP_W'(0)) begin
			mul_a = bx_q; mul_add = ax_q;
		end else if (cmd.idx == STEP_W'(3)) begin
			mul_a = by_q; mul_add = ay_q;
		end
		prod = PW'(mul_a) * PW'($signed({1'b0, quo_q[TW-1:0]}));
		rnd_a = (prod + HALF_F) >>> FRAC_BITS;
		rnd_b = (prod + HALF_F1) >>> (FRAC_BITS + 1);
		h_next = rnd_a[HW-1:0] + mul_add;
		fin = rnd_b[HW-1:0] + (use_y ? HW'(y1_q) : HW'(x1_q));
	end

	logic signed [POS_W-1:0] fin_sat;
	always_comb begin
		if (fin > SAT_HI)
			fin_sat = SAT_HI[POS_W-1:0];
		else if (fin < SAT_LO)
			fin_sat = SAT_LO[POS_W-1:0];
		else
			fin_sat = fin[POS_W-1:0];
	end

	logic [SPP_W:0] rem_n;
	assign rem_n = {rem_q[SPP_W-1:0], num_q[NW-1]};

	logic signed [VEC_W-1:0] xs, ys;
	logic signed [ANG_W-1:0] at;
	assign xs = vx_q >>> cmd.idx;
	assign ys = vy_q >>> cmd.idx;
	assign at = ANG_W'($signed({1'b0, atan_lookup(cmd.idx)}));

	logic signed [POS_W:0] dx, dy;
	assign dx = (POS_W+1)'(sx_q) - (POS_W+1)'(x1_q);
	assign dy = (POS_W+1)'(sy_q) - (POS_W+1)'(y1_q);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD_IN: begin
				nx_q <= pos_x; ny_q <= pos_y; nz_q <= pos_z;
				nqx_q <= quat_x; nqy_q <= quat_y; nqz_q <= quat_z; nqw_q <= quat_w;
				end_q <= path_end;
			end
			OP_LOAD_SEGA, OP_LOAD_SEGB: begin
				bx_q <= -e0x + (e1x <<< 1) + e1x - (e2x <<< 1) - e2x + e3x;
				ax_q <= (e0x <<< 1) - (e1x <<< 2) - e1x + (e2x <<< 2) - e3x;
				cx_q <= e2x - e0x;
				by_q <= -e0y + (e1y <<< 1) + e1y - (e2y <<< 1) - e2y + e3y;
				ay_q <= (e0y <<< 1) - (e1y <<< 2) - e1y + (e2y <<< 2) - e3y;
				cy_q <= e2y - e0y;
				x1_q <= p1x; y1_q <= p1y;
			end
			OP_DIV_INIT: begin
				num_q <= (NW'(cmd.s) << FRAC_BITS) + NW'(cmd.spp >> 1);
				rem_q <= '0;
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				num_q <= num_q << 1;
				if (rem_n >= {1'b0, cmd.spp}) begin
					rem_q <= rem_n - {1'b0, cmd.spp};
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rem_n;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
			end
			OP_MUL: begin
				case (cmd.idx)
					STEP_W'(0), STEP_W'(1): hx_q <= h_next;
					STEP_W'(2): sx_q <= fin_sat;
					STEP_W'(3), STEP_W'(4): hy_q <= h_next;
					default: sy_q <= fin_sat;
				endcase
			end
			OP_DIFF: begin
				vx_q <= VEC_W'(dx);
				vy_q <= VEC_W'(dy);
				zero_q <= (dx == '0) && (dy == '0);
			end
			OP_NORM: begin
				vx_q <= vx_q <<< 1;
				vy_q <= vy_q <<< 1;
			end
			OP_PREROT: begin
				if (vx_q < 0) begin
					if (vy_q >= 0) begin
						vx_q <= vy_q; vy_q <= -vx_q; z_q <= QUARTER_TURN;
					end else begin
						vx_q <= -vy_q; vy_q <= vx_q; z_q <= -QUARTER_TURN;
					end
				end else begin
					z_q <= '0;
				end
			end
			OP_VEC: begin
				if (vy_q > 0) begin
					vx_q <= vx_q + ys; vy_q <= vy_q - xs; z_q <= z_q + at;
				end else begin
					vx_q <= vx_q - ys; vy_q <= vy_q + xs; z_q <= z_q - at;
				end
			end
			OP_HALF: begin
				z_q <= z_q >>> 1;
				vx_q <= INV_GAIN_Q30;
				vy_q <= '0;
			end
			OP_ROT: begin
				if (z_q >= 0) begin
					vx_q <= vx_q - ys; vy_q <= vy_q + xs; z_q <= z_q - at;
				end else begin
					vx_q <= vx_q + ys; vy_q <= vy_q - xs; z_q <= z_q + at;
				end
			end
			OP_EMIT: begin
				out_x <= sx_q; out_y <= sy_q; out_z <= '0;
				out_qx <= '0; out_qy <= '0;
				out_qz <= zero_q ? '0 : q14(vy_q);
				out_qw <= zero_q ? Q14_ONE : q14(vx_q);
				run_last <= cmd.last;
			end
			OP_ECHO: begin
				out_x <= nx_q; out_y <= ny_q; out_z <= nz_q;
				out_qx <= nqx_q; out_qy <= nqy_q; out_qz <= nqz_q; out_qw <= nqw_q;
				run_last <= 1'b1;
			end
			OP_SHIFT_WIN: begin
				wx_q[0] <= wx_q[1]; wx_q[1] <= wx_q[2]; wx_q[2] <= nx_q;
				wy_q[0] <= wy_q[1]; wy_q[1] <= wy_q[2]; wy_q[2] <= ny_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT || cmd.op == OP_ECHO) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign st.out_free = !out_valid_q || out_ready;
	assign st.end_q = end_q;
	assign st.zero = zero_q;
	assign st.norm_done = (vx_q >= NORM_HI) || (vx_q <= NORM_LO) ||
		(vy_q >= NORM_HI) || (vy_q <= NORM_LO);

endmodule

>>> src/crps_ctrl.sv
module crps_ctrl import crps_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [SPP_W-1:0] cfg_data,
	input  stat_t            st,
	output cmd_t             cmd
);

	localparam int DIV_STEPS = FRAC_BITS + SPP_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECIDE, ST_SEGB, ST_DIVI, ST_DIV, ST_MUL, ST_DIFF, ST_NORM,
		ST_PRE, ST_VEC, ST_HALF, ST_ROT, ST_EMIT, ST_FINISH
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] cnt_q;
	logic [SPP_W-1:0]  s_q, spp_q;
	logic [1:0]        seen_q;
	logic              segb_q;
	logic              s_last;

	assign s_last = (s_q == spp_q - SPP_W'(1));
	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		cmd = '0;
		cmd.op = OP_NONE;
		cmd.idx = cnt_q;
		cmd.s = s_q;
		cmd.spp = spp_q;
		cmd.last = s_last && !st.end_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) cmd.op = OP_LOAD_IN;
			ST_DECIDE: begin
				cmd.sel = (seen_q == 2'd3);
				if (seen_q >= 2'd2 && spp_q != '0) cmd.op = OP_LOAD_SEGA;
			end
			ST_SEGB: begin
				cmd.sel = (seen_q >= 2'd2);
				if (st.end_q && seen_q != 2'd0 && spp_q != '0) cmd.op = OP_LOAD_SEGB;
			end
			ST_DIVI:   cmd.op = OP_DIV_INIT;
			ST_DIV:    cmd.op = OP_DIV_STEP;
			ST_MUL:    cmd.op = OP_MUL;
			ST_DIFF:   cmd.op = OP_DIFF;
			ST_NORM:   if (!st.zero && !st.norm_done) cmd.op = OP_NORM;
			ST_PRE:    cmd.op = OP_PREROT;
			ST_VEC:    cmd.op = OP_VEC;
			ST_HALF:   cmd.op = OP_HALF;
			ST_ROT:    cmd.op = OP_ROT;
			ST_EMIT:   if (st.out_free) cmd.op = OP_EMIT;
			ST_FINISH: begin
				if (!st.end_q) cmd.op = OP_SHIFT_WIN;
				else if (st.out_free) cmd.op = OP_ECHO;
			end
			default:   cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			s_q <= '0;
			spp_q <= SPP_RESET;
			seen_q <= '0;
			segb_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) spp_q <= cfg_data;
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_DECIDE;
				ST_DECIDE: begin
					s_q <= '0;
					segb_q <= 1'b0;
					if (cmd.op == OP_LOAD_SEGA) state_q <= ST_DIVI;
					else state_q <= ST_SEGB;
				end
				ST_SEGB: begin
					s_q <= '0;
					segb_q <= 1'b1;
					if (cmd.op == OP_LOAD_SEGB) state_q <= ST_DIVI;
					else state_q <= ST_FINISH;
				end
				ST_DIVI: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + STEP_W'(1);
					end
				end
				ST_MUL: begin
					if (cnt_q == STEP_W'(MUL_STEPS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_DIFF;
					end else begin
						cnt_q <= cnt_q + STEP_W'(1);
					end
				end
				ST_DIFF: state_q <= ST_NORM;
				ST_NORM: begin
					if (st.zero) state_q <= ST_EMIT;
					else if (st.norm_done) state_q <= ST_PRE;
				end
				ST_PRE: begin
					cnt_q <= '0;
					state_q <= ST_VEC;
				end
				ST_VEC: begin
					if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_HALF;
					end else begin
						cnt_q <= cnt_q + STEP_W'(1);
					end
				end
				ST_HALF: state_q <= ST_ROT;
				ST_ROT: begin
					if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + STEP_W'(1);
					end
				end
				ST_EMIT: begin
					if (st.out_free) begin
						if (s_last) begin
							state_q <= segb_q ? ST_FINISH : ST_SEGB;
						end else begin
							s_q <= s_q + SPP_W'(1);
							state_q <= ST_DIVI;
						end
					end
				end
				ST_FINISH: begin
					if (!st.end_q) begin
						if (seen_q != 2'd3) seen_q <= seen_q + 2'd1;
						state_q <= ST_IDLE;
					end else if (st.out_free) begin
						seen_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT || cmd.op == OP_ECHO) |-> st.out_free)
		else $error("result written over an untaken one");

	a_sample_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (s_q < spp_q))
		else $error("sample index beyond segment length");

	a_echo_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ECHO) |=> (seen_q == 2'd0 && state_q == ST_IDLE))
		else $error("path end did not clear the window count");

endmodule

>>> src/catmull_rom_path_sampler_core.sv
// Per waypoint the controller steps through its decide, segment and finish states; per emitted
// sample it runs divider setup and a bit-serial divide for t, six Horner steps, a difference step,
// normalisation, two 31-step CORDIC passes, halving and emit on one shared unit, and emit waits
// for a free result slot. Normalisation and CORDIC are skipped when the yaw vector is zero (segment start).
// Throughput: one waypoint in flight at a time; up to 2*S+1 results per waypoint.
// Reset (arst_n low, asynchronous): controller idle, window empty, S = 10, no result pending.
module catmull_rom_path_sampler_core import crps_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [SPP_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic signed [QUAT_W-1:0] quat_x,
	input  logic signed [QUAT_W-1:0] quat_y,
	input  logic signed [QUAT_W-1:0] quat_z,
	input  logic signed [QUAT_W-1:0] quat_w,
	input  logic                     path_end,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [POS_W-1:0]  out_x,
	output logic signed [POS_W-1:0]  out_y,
	output logic signed [POS_W-1:0]  out_z,
	output logic signed [QUAT_W-1:0] out_qx,
	output logic signed [QUAT_W-1:0] out_qy,
	output logic signed [QUAT_W-1:0] out_qz,
	output logic signed [QUAT_W-1:0] out_qw,
	output logic                     run_last
);

	cmd_t  cmd;
	stat_t st;

	crps_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.st        (st),
		.cmd       (cmd)
	);

	crps_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.quat_w    (quat_w),
		.path_end  (path_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_qx    (out_qx),
		.out_qy    (out_qy),
		.out_qz    (out_qz),
		.out_qw    (out_qw),
		.run_last  (run_last)
	);

endmodule

>>> test/catmull_rom_path_sampler_core_test.sv
`timescale 1ns / 1ps

module catmull_rom_path_sampler_core_test;
	import crps_pkg::*;

	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int DRAIN_CYCLES = 300;
	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint POS_MIN = -64'sd2147483648;
	localparam longint ARCTAN [31] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1};

	typedef struct packed {
		logic signed [POS_W-1:0]  x;
		logic signed [POS_W-1:0]  y;
		logic signed [POS_W-1:0]  z;
		logic signed [QUAT_W-1:0] qx;
		logic signed [QUAT_W-1:0] qy;
		logic signed [QUAT_W-1:0] qz;
		logic signed [QUAT_W-1:0] qw;
		logic                     path_end;
	} waypoint_t;

	typedef struct packed {
		logic signed [POS_W-1:0]  x;
		logic signed [POS_W-1:0]  y;
		logic signed [POS_W-1:0]  z;
		logic signed [QUAT_W-1:0] qx;
		logic signed [QUAT_W-1:0] qy;
		logic signed [QUAT_W-1:0] qz;
		logic signed [QUAT_W-1:0] qw;
		logic                     last;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [SPP_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [QUAT_W-1:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
	logic path_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [POS_W-1:0] out_x, out_y, out_z;
	logic signed [QUAT_W-1:0] out_qx, out_qy, out_qz, out_qw;
	logic run_last;

	sample_t expected_samples[$];
	longint win_x[3], win_y[3];
	int points_held;
	int spp_model;
	int errors = 0;
	int samples_checked = 0;
	int waypoints_sent = 0;
	int cycle_count = 0;
	int hold_request = 0;
	bit no_idle = 1'b0;

	catmull_rom_path_sampler_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
		.path_end(path_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.out_qx(out_qx), .out_qy(out_qy), .out_qz(out_qz), .out_qw(out_qw),
		.run_last(run_last)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d requests outstanding", cycle_count,
				expected_samples.size());
			$display("status: fail");
			$finish;
		end
	end

	function automatic longint round_shift(longint v, int n);
		if (n == 0)
			return v;
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint spline_at(longint p0, longint p1, longint p2, longint p3,
		longint t);
		longint b, a, c, h;
		b = -p0 + 3 * p1 - 3 * p2 + p3;
		a = 2 * p0 - 5 * p1 + 4 * p2 - p3;
		c = p2 - p0;
		h = round_shift(b * t, FRAC_BITS_DEF) + a;
		h = round_shift(h * t, FRAC_BITS_DEF) + c;
		h = round_shift(h * t, FRAC_BITS_DEF + 1) + p1;
		if (h > POS_MAX)
			h = POS_MAX;
		if (h < POS_MIN)
			h = POS_MIN;
		return h;
	endfunction

	function automatic logic signed [QUAT_W-1:0] to_q14(longint v);
		longint r;
		r = round_shift(v, 16);
		if (r > 16384)
			r = 16384;
		if (r < -16384)
			r = -16384;
		return r[QUAT_W-1:0];
	endfunction

	// half-yaw quaternion of (dx, dy): vectoring pass, halve, rotation pass
	task automatic half_yaw(input longint dx, input longint dy,
		output logic signed [QUAT_W-1:0] qz, output logic signed [QUAT_W-1:0] qw);
		longint x, y, z, nx, m, ax, ay;
		int k;
		z = 0;
		k = 0;
		if (dx == 0 && dy == 0) begin
			qz = 0;
			qw = Q14_ONE;
			return;
		end
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		m = ax > ay ? ax : ay;
		while (m < (longint'(1) <<< NORM_BIT)) begin
			m = m <<< 1;
			k++;
		end
		x = dx * (longint'(1) <<< k);
		y = dy * (longint'(1) <<< k);
		if (x < 0) begin
			if (y >= 0) begin
				nx = y; y = -x; x = nx; z = QUARTER_TURN;
			end else begin
				nx = -y; y = x; x = nx; z = -QUARTER_TURN;
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i); y = y - (x >>> i); z += ARCTAN[i];
			end else begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= ARCTAN[i];
			end
			x = nx;
		end
		z = z >>> 1;
		x = INV_GAIN_Q30;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= ARCTAN[i];
			end else begin
				nx = x + (y >>> i); y = y - (x >>> i); z += ARCTAN[i];
			end
			x = nx;
		end
		qw = to_q14(x);
		qz = to_q14(y);
	endtask

	task automatic sample_segment(input longint x0, y0, x1, y1, x2, y2, x3, y3,
		ref sample_t run[$]);
		longint t, cx, cy;
		sample_t smp;
		for (int s = 0; s < spp_model; s++) begin
			t = ((longint'(s) <<< FRAC_BITS_DEF) + spp_model / 2) / spp_model;
			cx = spline_at(x0, x1, x2, x3, t);
			cy = spline_at(y0, y1, y2, y3, t);
			smp = '0;
			smp.x = cx[POS_W-1:0];
			smp.y = cy[POS_W-1:0];
			half_yaw(cx - x1, cy - y1, smp.qz, smp.qw);
			run = {run, smp};
		end
	endtask

	// advances the path window and queues every sample the waypoint releases
	task automatic predict_samples(input waypoint_t wp);
		sample_t run[$];
		sample_t echo;
		longint nx, ny;
		bit full;
		nx = wp.x;
		ny = wp.y;
		full = points_held == 3;
		if (points_held >= 2)
			sample_segment(full ? win_x[0] : win_x[1], full ? win_y[0] : win_y[1],
				win_x[1], win_y[1], win_x[2], win_y[2], nx, ny, run);
		if (!wp.path_end) begin
			win_x[0] = win_x[1]; win_x[1] = win_x[2]; win_x[2] = nx;
			win_y[0] = win_y[1]; win_y[1] = win_y[2]; win_y[2] = ny;
			if (points_held < 3)
				points_held++;
		end else begin
			if (points_held >= 1)
				sample_segment(points_held >= 2 ? win_x[1] : win_x[2],
					points_held >= 2 ? win_y[1] : win_y[2],
					win_x[2], win_y[2], nx, ny, nx, ny, run);
			echo = {wp.x, wp.y, wp.z, wp.qx, wp.qy, wp.qz, wp.qw, 1'b0};
			run = {run, echo};
			win_x = '{0, 0, 0};
			win_y = '{0, 0, 0};
			points_held = 0;
		end
		if (run.size() > 0)
			run[run.size() - 1].last = 1'b1;
		expected_samples = {expected_samples, run};
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	function automatic longint random_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return longint'(signed'(32'($urandom)));
		if (r < 80)
			return longint'($urandom_range(0, 1 << 24)) - (1 << 23);
		return longint'($urandom_range(0, 1 << 17)) - (1 << 16);
	endfunction

	function automatic waypoint_t make_wp(longint x, y, z, int qx, qy, qz, qw, bit e);
		waypoint_t wp;
		wp.x = x[POS_W-1:0];
		wp.y = y[POS_W-1:0];
		wp.z = z[POS_W-1:0];
		wp.qx = qx[QUAT_W-1:0];
		wp.qy = qy[QUAT_W-1:0];
		wp.qz = qz[QUAT_W-1:0];
		wp.qw = qw[QUAT_W-1:0];
		wp.path_end = e;
		return wp;
	endfunction

	function automatic waypoint_t random_wp(bit e);
		return make_wp(random_coord(), random_coord(), longint'(signed'(32'($urandom))),
			int'($urandom_range(0, 32768)) - 16384, int'($urandom_range(0, 32768)) - 16384,
			int'($urandom_range(0, 32768)) - 16384, int'($urandom_range(0, 32768)) - 16384,
			e);
	endfunction

	// request handshake; valid stays high across back-to-back requests
	task automatic send_wp(input waypoint_t wp);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, path_end} <= wp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		waypoints_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		// waypoints that release nothing may still be in the pipe
		repeat (200) @(posedge clk);
	endtask

	task automatic write_spp(input int value);
		cfg_valid <= 1'b1;
		cfg_data <= value[SPP_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		spp_model = value;
	endtask

	task automatic check_sample();
		sample_t got, want;
		got = {out_x, out_y, out_z, out_qx, out_qy, out_qz, out_qw, run_last};
		if (expected_samples.size() == 0) begin
			$display("%0t: unexpected sample %h", $time, got);
			errors++;
			return;
		end
		want = expected_samples.pop_front();
		samples_checked++;
		if (got.x !== want.x)
			$display("%0t: out_x expected %0d got %0d", $time, want.x, got.x);
		if (got.y !== want.y)
			$display("%0t: out_y expected %0d got %0d", $time, want.y, got.y);
		if (got.z !== want.z)
			$display("%0t: out_z expected %0d got %0d", $time, want.z, got.z);
		if (got.qx !== want.qx)
			$display("%0t: out_qx expected %0d got %0d", $time, want.qx, got.qx);
		if (got.qy !== want.qy)
			$display("%0t: out_qy expected %0d got %0d", $time, want.qy, got.qy);
		if (got.qz !== want.qz)
			$display("%0t: out_qz expected %0d got %0d", $time, want.qz, got.qz);
		if (got.qw !== want.qw)
			$display("%0t: out_qw expected %0d got %0d", $time, want.qw, got.qw);
		if (got.last !== want.last)
			$display("%0t: run_last expected %0b got %0b", $time, want.last, got.last);
		if (got !== want)
			errors++;
	endtask

	// result side: random stalls, plus a long hold-off when asked for
	initial begin
		int stall_left, hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				check_sample();
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = gap_len();
			end
		end
	end

	initial begin
		waypoint_t directed_rows[16];
		bit directed_echo[16];
		int phase_spp[10];
		int quota, sent, len;
		sample_t echo;

		directed_echo = '{default: 1'b0};
		// lone waypoints, at the field extremes and at the origin, are simply echoed
		directed_rows[0] = make_wp(POS_MAX, POS_MIN, POS_MIN, 16384, -16384, 16384, -16384, 1);
		directed_echo[0] = 1'b1;
		directed_rows[1] = make_wp(0, 0, 0, 0, 0, 0, 0, 1);
		directed_echo[1] = 1'b1;
		// corner to corner: saturating curve
		directed_rows[2] = make_wp(POS_MIN, POS_MIN, 0, 0, 0, 0, 0, 0);
		directed_rows[3] = make_wp(POS_MAX, POS_MAX, 0, 0, 0, 0, 0, 0);
		directed_rows[4] = make_wp(POS_MIN, POS_MAX, 0, 0, 0, 0, 0, 0);
		directed_rows[5] = make_wp(POS_MAX, POS_MIN, 0, 0, 0, 0, 0, 0);
		directed_rows[6] = make_wp(0, 0, POS_MAX, -16384, 16384, -16384, 16384, 1);
		// two-point path
		directed_rows[7] = make_wp(1 << 16, 0, 0, 0, 0, 0, 0, 0);
		directed_rows[8] = make_wp(2 << 16, 1 << 16, 5, 1, 2, 3, 4, 1);
		// longer path through all four quadrants
		directed_rows[9] = make_wp(-(3 << 16), 1 << 16, 0, 0, 0, 0, 0, 0);
		directed_rows[10] = make_wp(-(1 << 16), -(2 << 16), 0, 0, 0, 0, 0, 0);
		directed_rows[11] = make_wp(2 << 16, -(1 << 16), 0, 0, 0, 0, 0, 0);
		directed_rows[12] = make_wp(3 << 16, 3 << 16, 0, 0, 0, 0, 0, 0);
		directed_rows[13] = make_wp(-(1 << 16), 4 << 16, 0, 0, 0, 0, 0, 0);
		directed_rows[14] = make_wp(-(5 << 16), 0, -7, 100, -100, 200, -200, 1);
		directed_rows[15] = make_wp(12345, -54321, 1, 16384, 16384, 16384, 16384, 1);
		directed_echo[15] = 1'b1;

		phase_spp = '{1, 4, 0, 31, 2, 10, 5, 1, 3, 6};

		win_x = '{0, 0, 0};
		win_y = '{0, 0, 0};
		points_held = 0;
		spp_model = SPP_RESET;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_wp(directed_rows[i]);
			if (directed_echo[i]) begin
				echo = {directed_rows[i][POS_W*3+QUAT_W*4:1], 1'b1};
				expected_samples = {expected_samples, echo};
				points_held = 0;
			end else begin
				predict_samples(directed_rows[i]);
			end
		end

		foreach (phase_spp[p]) begin
			wait_drained();
			write_spp(phase_spp[p]);
			no_idle = (p == 6);
			// receiver holds off long enough for the input side to back up
			if (p == 5)
				hold_request = 2500;
			quota = phase_spp[p] == 31 ? 6 : (phase_spp[p] == 0 ? 10 : 30);
			sent = 0;
			while (sent < quota) begin
				if ($urandom_range(0, 19) == 0)
					wait_drained();
				len = phase_spp[p] == 31 ? $urandom_range(1, 3) : $urandom_range(1, 7);
				for (int k = 0; k < len; k++) begin
					waypoint_t wp;
					wp = random_wp(k == len - 1);
					send_wp(wp);
					predict_samples(wp);
					sent++;
				end
			end
		end
		no_idle = 1'b0;

		in_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d waypoints over %0d sample-count settings, including zero and 31;",
			waypoints_sent, $size(phase_spp) + 1);
		$display("%0d samples and echoes checked, %0d mismatches", samples_checked, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
